[rtl/core/lbpf_pkg.sv]
// ----------------------------------------------------------------------------
// lbpf_pkg: shared types and constants of the label boundary pixel finder
// Holds the pixel word layout, record tags, line buffer request struct and
// the job handed from the window logic to the record emitter.
// ----------------------------------------------------------------------------
package lbpf_pkg;

  localparam int MAX_COLS   = 2048;
  localparam int LABEL_BITS = 32;

  // Line buffer address width and a column count width that can hold MAX_COLS.
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);

  // Port field widths.
  localparam int LABEL_W      = 32;
  localparam int ROWS_W       = 16;
  localparam int COLS_W       = 12;
  localparam int CFG_W        = 16;
  localparam int TAG_W        = 3;
  localparam int CELL_ROW_W   = 16;
  localparam int CELL_COL_W   = 12;
  localparam int S_TDATA_W    = 32;
  localparam int M_TDATA_W    = 32;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Record tags.
  localparam logic [TAG_W-1:0] TAG_NORTH  = 3'd0;
  localparam logic [TAG_W-1:0] TAG_EAST   = 3'd1;
  localparam logic [TAG_W-1:0] TAG_SOUTH  = 3'd2;
  localparam logic [TAG_W-1:0] TAG_WEST   = 3'd3;
  localparam logic [TAG_W-1:0] TAG_CENTRE = 3'd5;

  // Bit positions of the neighbour mask, in judging order.
  localparam int DIR_NORTH = 0;
  localparam int DIR_EAST  = 1;
  localparam int DIR_SOUTH = 2;
  localparam int DIR_WEST  = 3;

  typedef struct packed {
    logic                  miss;
    logic [LABEL_BITS-1:0] label;
  } pixel_t;

  // One cycle of line buffer traffic.
  typedef struct packed {
    logic             en;       // read both buffers
    logic             wr;       // shift the current column down
    logic [COL_W-1:0] rd_addr;  // column prefetched from the row above
    logic [COL_W-1:0] wr_addr;  // current column
    pixel_t           cur;      // incoming pixel
    pixel_t           centre;   // pixel of the row above at this column
  } lb_req_t;

  // Work for the record emitter: one centre and its differing neighbours.
  typedef struct packed {
    logic [3:0]            mask;
    logic [CELL_ROW_W-1:0] row;
    logic [COL_W-1:0]      col;
  } job_t;

endpackage

[rtl/core/lbpf_line_buf.sv]
// ----------------------------------------------------------------------------
// lbpf_line_buf: the two line buffers
// Synchronous memories of the row above and the row two above, read-first,
// with a bypass for a prefetch that hits the column being written.
// ----------------------------------------------------------------------------
module lbpf_line_buf (
  input  logic              clk,
  input  logic              rst,
  input  lbpf_pkg::lb_req_t req,
  output lbpf_pkg::pixel_t  la_q,
  output lbpf_pkg::pixel_t  lta_q
);
  import lbpf_pkg::*;

  pixel_t la_mem  [MAX_COLS];
  pixel_t lta_mem [MAX_COLS];
  pixel_t la_ram_q;
  pixel_t fwd_data;
  logic   fwd;

  always_ff @(posedge clk) begin
    if (req.en) begin
      la_ram_q <= la_mem[req.rd_addr];
    end
    if (req.wr) begin
      la_mem[req.wr_addr] <= req.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      lta_q <= lta_mem[req.wr_addr];
    end
    if (req.wr) begin
      lta_mem[req.wr_addr] <= req.centre;
    end
  end

  // A one-column row reads back the pixel it is writing.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (req.en) begin
      fwd <= req.wr && (req.rd_addr == req.wr_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      fwd_data <= req.cur;
    end
  end

  assign la_q = fwd ? fwd_data : la_ram_q;

endmodule

[rtl/core/lbpf_window.sv]
// ----------------------------------------------------------------------------
// lbpf_window: raster position, line buffer control and neighbour compare
// Tracks row and column, drives the line buffers, and judges each centre in the
// cycle after its south pixel is taken, when the east and north reads land.
// ----------------------------------------------------------------------------
module lbpf_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lbpf_pkg::LABEL_W-1:0]  in_label,
  input  logic                          in_missing,
  input  logic [lbpf_pkg::ROWS_W-1:0]   raster_rows,
  input  logic [lbpf_pkg::COLS_W-1:0]   raster_cols,
  input  logic                          cfg_touch,
  output lbpf_pkg::lb_req_t             lb_req,
  input  lbpf_pkg::pixel_t              la_q,
  input  lbpf_pkg::pixel_t              lta_q,
  output logic                          job_valid,
  input  logic                          job_ready,
  output lbpf_pkg::job_t                job
);
  import lbpf_pkg::*;

  logic [ROWS_W-1:0] row_counter, row_counter_next;
  logic [COL_W-1:0]  col_counter, col_counter_next;
  logic              refetch;
  pixel_t            west;

  logic [ROWS_W-1:0] rows;
  logic [CNT_W-1:0]  cols;
  logic              col_wrap;
  logic [COL_W-1:0]  c_eff;
  logic [ROWS_W:0]   r_pre;
  logic [ROWS_W-1:0] r_eff;
  logic [CNT_W-1:0]  c1;
  logic              east_ok;
  logic [ROWS_W:0]   r1;
  logic [COL_W-1:0]  next_addr;
  logic              judge;
  logic              accept;
  pixel_t            cur;

  logic              s2_valid;
  logic [ROWS_W-1:0] s2_row;
  logic [COL_W-1:0]  s2_col;
  pixel_t            s2_cur;
  pixel_t            s2_centre;
  pixel_t            s2_west;
  logic              s2_east_ok;
  logic              s2_judge;
  pixel_t            east;
  pixel_t            nb [4];
  logic [3:0]        mask;
  logic              s2_free;

  // Zero dimensions act as one; wide rows are clipped to the buffer depth.
  always_comb begin
    rows = (raster_rows == '0) ? ROWS_W'(1) : raster_rows;
    if (raster_cols == '0) begin
      cols = CNT_W'(1);
    end else if (32'(raster_cols) > 32'(MAX_COLS)) begin
      cols = CNT_W'(MAX_COLS);
    end else begin
      cols = CNT_W'(raster_cols);
    end
  end

  // Position of this pixel, allowing for a reconfiguration since the last one.
  always_comb begin
    col_wrap  = CNT_W'(col_counter) >= cols;
    c_eff     = col_wrap ? '0 : col_counter;
    r_pre     = {1'b0, row_counter} + (ROWS_W + 1)'(col_wrap);
    r_eff     = (r_pre >= {1'b0, rows}) ? '0 : r_pre[ROWS_W-1:0];
    c1        = CNT_W'(c_eff) + CNT_W'(1);
    east_ok   = c1 < cols;
    next_addr = east_ok ? c1[COL_W-1:0] : '0;
    r1        = {1'b0, r_eff} + (ROWS_W + 1)'(1);
    if (east_ok) begin
      col_counter_next = c1[COL_W-1:0];
      row_counter_next = r_eff;
    end else begin
      col_counter_next = '0;
      row_counter_next = (r1 >= {1'b0, rows}) ? '0 : r1[ROWS_W-1:0];
    end
    judge = (r_eff >= ROWS_W'(2)) && (c_eff != '0) && east_ok && !la_q.miss;
  end

  assign cur      = '{miss: in_missing, label: in_label[LABEL_BITS-1:0]};
  assign s2_free  = !s2_valid || (mask == '0) || job_ready;
  assign in_ready = !refetch && s2_free;
  assign accept   = in_valid && in_ready;

  // On a pixel: prefetch the next column's centre, read north, shift the
  // column down. After reset or a register write: refetch this centre.
  always_comb begin
    lb_req.en      = accept || refetch;
    lb_req.wr      = accept;
    lb_req.rd_addr = accept ? next_addr : c_eff;
    lb_req.wr_addr = c_eff;
    lb_req.cur     = cur;
    lb_req.centre  = la_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
      col_counter <= '0;
      refetch     <= 1'b1;
      west        <= '0;
      s2_valid    <= 1'b0;
    end else begin
      refetch <= cfg_touch;
      if (accept) begin
        row_counter <= row_counter_next;
        col_counter <= col_counter_next;
        west        <= la_q;
        s2_valid    <= 1'b1;
      end else if (s2_free) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_row     <= r_eff;
      s2_col     <= c_eff;
      s2_cur     <= cur;
      s2_centre  <= la_q;
      s2_west    <= west;
      s2_east_ok <= east_ok;
      s2_judge   <= judge;
    end
  end

  always_comb begin
    east         = s2_east_ok ? la_q : '0;
    nb[DIR_NORTH] = lta_q;
    nb[DIR_EAST]  = east;
    nb[DIR_SOUTH] = s2_cur;
    nb[DIR_WEST]  = s2_west;
    for (int k = 0; k < 4; k++) begin
      mask[k] = s2_judge && (nb[k].miss || (nb[k] != s2_centre));
    end
  end

  assign job_valid = s2_valid && (mask != '0);
  assign job       = '{mask: mask, row: s2_row, col: s2_col};

endmodule

[rtl/core/lbpf_emit.sv]
// ----------------------------------------------------------------------------
// lbpf_emit: record emitter
// Holds one judged centre and sends a centre record and a neighbour record
// for each differing direction, north first.
// ----------------------------------------------------------------------------
module lbpf_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  lbpf_pkg::job_t                   job,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbpf_pkg::TAG_W-1:0]       cell_tag,
  output logic [lbpf_pkg::CELL_ROW_W-1:0]  cell_row,
  output logic [lbpf_pkg::CELL_COL_W-1:0]  cell_col,
  output logic                             last_of_run
);
  import lbpf_pkg::*;

  typedef enum logic [1:0] {
    PH_CENTRE = 2'b01,
    PH_NEIGH  = 2'b10
  } phase_t;

  logic                  busy;
  phase_t                phase;
  logic [3:0]            mask;
  logic [CELL_ROW_W-1:0] row;
  logic [CELL_COL_W-1:0] col0;
  logic [CELL_COL_W-1:0] col1;
  logic [3:0]            sel;
  logic [TAG_W-1:0]      dir_tag;
  logic [CELL_ROW_W-1:0] nb_row;
  logic [CELL_COL_W-1:0] nb_col;
  logic                  done;

  assign col1 = col0 + CELL_COL_W'(1);
  assign sel  = mask & (~mask + 4'd1);

  always_comb begin
    dir_tag = TAG_WEST;
    nb_row  = row;
    nb_col  = col0;
    priority if (mask[DIR_NORTH]) begin
      dir_tag = TAG_NORTH;
      nb_row  = row - CELL_ROW_W'(1);
      nb_col  = col1;
    end else if (mask[DIR_EAST]) begin
      dir_tag = TAG_EAST;
      nb_col  = col1 + CELL_COL_W'(1);
    end else if (mask[DIR_SOUTH]) begin
      dir_tag = TAG_SOUTH;
      nb_row  = row + CELL_ROW_W'(1);
      nb_col  = col1;
    end else begin
      dir_tag = TAG_WEST;
    end
  end

  always_comb begin
    out_valid = busy;
    unique case (phase)
      PH_CENTRE: begin
        cell_tag    = TAG_CENTRE;
        cell_row    = row;
        cell_col    = col1;
        last_of_run = 1'b0;
      end
      PH_NEIGH: begin
        cell_tag    = dir_tag;
        cell_row    = nb_row;
        cell_col    = nb_col;
        last_of_run = (mask & ~sel) == '0;
      end
      default: begin
        cell_tag    = TAG_CENTRE;
        cell_row    = row;
        cell_col    = col1;
        last_of_run = 1'b0;
      end
    endcase
  end

  assign done      = busy && out_ready && last_of_run;
  assign job_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_CENTRE;
    end else if (job_valid && job_ready) begin
      busy  <= 1'b1;
      phase <= PH_CENTRE;
    end else if (done) begin
      busy  <= 1'b0;
      phase <= PH_CENTRE;
    end else if (busy && out_ready) begin
      phase <= (phase == PH_CENTRE) ? PH_NEIGH : PH_CENTRE;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      mask <= job.mask;
      row  <= job.row;
      col0 <= CELL_COL_W'(job.col);
    end else if (busy && out_ready && (phase == PH_NEIGH)) begin
      mask <= mask & ~sel;
    end
  end

endmodule

[rtl/core/label_boundary_pixel_finder_unit.sv]
// ----------------------------------------------------------------------------
// label_boundary_pixel_finder_unit: four-neighbour label boundary finder
// Streams a label raster and reports every interior, non-missing centre pixel
// that borders a different or missing label, together with that neighbour.
// ----------------------------------------------------------------------------
// Usage. Pixels enter on the s_ channel in row-major order, one request per
// pixel: s_tdata carries the label, s_tuser the missing flag. Records leave on
// the m_ channel; m_tlast marks the final record caused by one pixel. Rows and
// columns per frame are set through the write port while the block is idle.
//
// The block takes one pixel per cycle while s_tready is high. A pixel whose
// centre (the pixel of the row above) differs in k directions produces 2k
// records, one per cycle while m_tready is high, and the input pauses, apart
// from the refetch after reset or a register write, only while the emitter
// still holds an earlier centre. The first record of a pixel is presented once
// the line buffer reads of the east and north neighbours have landed and the
// emitter has been loaded. The line buffer reads are registered.
//
// After reset, and in the cycle after each register write, s_tready is low
// while the centre of the next column is read from the line buffer. When the
// receiver holds m_tready low, the current record stays on m_tdata, and the
// input keeps flowing until a second bordering centre is waiting behind it.
// ----------------------------------------------------------------------------
module label_boundary_pixel_finder_unit (
  input  logic                            clk,
  input  logic                            rst,
  // pixel requests
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lbpf_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] pixel_label
  input  logic                            s_tuser,   // [0] pixel_missing
  // record requests
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lbpf_pkg::M_TDATA_W-1:0]  m_tdata,   // [2:0] cell_tag, [18:3] cell_row,
                                                     // [30:19] cell_col, [31] zero
  output logic                            m_tlast,   // last_of_run
  // register writes
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [lbpf_pkg::CFG_W-1:0]      cfg_wdata
);
  import lbpf_pkg::*;

  logic [ROWS_W-1:0]     raster_rows;
  logic [COLS_W-1:0]     raster_cols;
  lb_req_t               lb_req;
  pixel_t                la_q;
  pixel_t                lta_q;
  logic                  job_valid;
  logic                  job_ready;
  job_t                  job;
  logic [TAG_W-1:0]      cell_tag;
  logic [CELL_ROW_W-1:0] cell_row;
  logic [CELL_COL_W-1:0] cell_col;

  // Frame geometry registers; both reset to a 3 by 3 frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      raster_rows <= ROWS_W'(3);
      raster_cols <= COLS_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROWS: raster_rows <= cfg_wdata[ROWS_W-1:0];
        REG_COLS: raster_cols <= cfg_wdata[COLS_W-1:0];
        default:  raster_rows <= raster_rows;
      endcase
    end
  end

  lbpf_line_buf u_line_buf (
    .clk   (clk),
    .rst   (rst),
    .req   (lb_req),
    .la_q  (la_q),
    .lta_q (lta_q)
  );

  // Position tracking and the compare of the four neighbours.
  lbpf_window u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_label    (s_tdata[LABEL_W-1:0]),
    .in_missing  (s_tuser),
    .raster_rows (raster_rows),
    .raster_cols (raster_cols),
    .cfg_touch   (cfg_wr_en),
    .lb_req      (lb_req),
    .la_q        (la_q),
    .lta_q       (lta_q),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job)
  );

  // Records go out one per cycle while m_tready is high, from a registered job.
  lbpf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .cell_tag    (cell_tag),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .last_of_run (m_tlast)
  );

  assign m_tdata = {1'b0, cell_col, cell_row, cell_tag};

endmodule

[rtl/core/lbpf_checker.sv]
// ----------------------------------------------------------------------------
// lbpf_checker: port-level checks of the boundary finder
// Watches the record channel for the centre and neighbour pairing.
// ----------------------------------------------------------------------------
module lbpf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lbpf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import lbpf_pkg::*;

  logic [TAG_W-1:0] tag;
  assign tag = m_tdata[TAG_W-1:0];

  // A stalled record holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("record changed while stalled");

  // A run always ends on a neighbour record.
  a_last_nb: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> tag != TAG_CENTRE)
    else $error("run ends on a centre record");

  // A centre record is followed at once by its neighbour.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && tag == TAG_CENTRE |=> m_tvalid && tag != TAG_CENTRE)
    else $error("centre record without its neighbour");

  // Within a run, a neighbour record is followed at once by the next centre.
  a_next: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && tag != TAG_CENTRE && !m_tlast |=>
      m_tvalid && tag == TAG_CENTRE)
    else $error("run broken after a neighbour record");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("record offered after reset");

endmodule

bind label_boundary_pixel_finder_unit lbpf_checker u_lbpf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
